// ===== rtl/core/lru_key_value_cache_unit_assert.svh =====
// Assertion macros for the LRU key/value cache: same-cycle and next-cycle implication checks.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define LRUKV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrukv: same-cycle check failed");
// Antecedent implies consequent in the next cycle.
`define LRUKV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrukv: next-cycle check failed");
`else
`define LRUKV_ASSERT_SAME(label, ante, cons)
`define LRUKV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/lrukv_pkg.sv =====
// Shared constants and types for the LRU key/value cache.
package lrukv_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 16;
    localparam int DEF_VALUE_BITS = 32;

    // Capacity register
    localparam int                CFG_BITS  = 5;
    localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

    // Command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Operation broadcast to the cell row
    typedef enum logic [1:0] {
        OP_NONE,
        OP_HIT,
        OP_FILL,
        OP_EVICT
    } lrukv_op_t;

    typedef struct packed {
        lrukv_op_t op;
        logic      wr_value;
    } lrukv_ctl_t;

endpackage

// ===== rtl/core/lrukv_if.sv =====
// Channel interfaces of the LRU key/value cache: request, response and capacity write.
interface lrukv_req_if #(
    parameter int KEY_BITS   = lrukv_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lrukv_pkg::DEF_VALUE_BITS
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [KEY_BITS-1:0]          key;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output cmd, output key, output value, input ready);
    modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lrukv_rsp_if #(
    parameter int VALUE_BITS = lrukv_pkg::DEF_VALUE_BITS
);
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [VALUE_BITS-1:0] read_value;
    logic                         evicted;

    modport source (output valid, output hit, output read_value, output evicted, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted, output ready);
endinterface

interface lrukv_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lrukv_pkg::CFG_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/lru_key_value_cache_unit.sv =====
// Top level of the LRU key/value cache: cell row, operation decode, capacity and result register.
// Fully associative key/value cache of ENTRIES cells with least-recently-used replacement.
// For a get or put item all cells compare the key at once, the operation is decided and, at the
// accepting edge, the row updates valid bits and ranks, the target cell its key and, on a put,
// its value; the result sits in an output register from the next cycle on. One item per clock is
// sustained while the response side takes results; the critical path is the key compare across
// the cell row, the rank and hit chain from cell to cell, and the rank update. Valid bits and
// ranks clear at reset, so the cache is usable at once. The capacity register (reset 16, 0 acts
// as 1, values above ENTRIES act as ENTRIES) may be written only while no item is outstanding.
`include "lru_key_value_cache_unit_assert.svh"

module lru_key_value_cache_unit #(
    parameter int ENTRIES    = lrukv_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lrukv_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lrukv_pkg::DEF_VALUE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    lrukv_cfg_if.sink   cfg,
    lrukv_req_if.sink   req,
    lrukv_rsp_if.source rsp
);
    import lrukv_pkg::*;

    localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);
    localparam int CMP_BITS  = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;

    logic [CFG_BITS-1:0]   cap_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] read_value_reg;
    logic                  evicted_reg;

    logic                  accept;
    logic                  is_put;
    logic [CMP_BITS-1:0]   cap_wide;
    logic [CMP_BITS-1:0]   cap_eff;
    logic                  fill_ok;
    lrukv_op_t             op;
    lrukv_ctl_t            ctl;
    logic [RANK_BITS-1:0]  old_rank;
    logic [RANK_BITS-1:0]  last_rank;

    logic                  free_link  [ENTRIES+1];
    logic                  hit_link   [ENTRIES+1];
    logic [VALUE_BITS-1:0] value_link [ENTRIES+1];
    logic [RANK_BITS-1:0]  rank_link  [ENTRIES+1];
    logic [ENTRIES-1:0]    valid_vec;
    logic [ENTRIES-1:0]    match_vec;

    // Handshakes
    assign cfg.ready = 1'b1;
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_put    = (req.cmd == CMD_PUT);

    // Effective capacity, clamped to 1..ENTRIES
    assign cap_wide = CMP_BITS'(cap_reg);
    always_comb
    begin
        if (cap_wide == '0)
        begin
            cap_eff = CMP_BITS'(1);
        end
        else if (cap_wide > CMP_BITS'(ENTRIES))
        begin
            cap_eff = CMP_BITS'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_wide;
        end
    end
    assign fill_ok = (CMP_BITS'(count_reg) < cap_eff) && free_link[ENTRIES];

    // Operation decode
    always_comb
    begin
        if (!accept)
        begin
            op = OP_NONE;
        end
        else if (hit_link[ENTRIES])
        begin
            op = OP_HIT;
        end
        else if (!is_put)
        begin
            op = OP_NONE;
        end
        else if (fill_ok)
        begin
            op = OP_FILL;
        end
        else
        begin
            op = OP_EVICT;
        end
    end

    assign ctl.op       = op;
    assign ctl.wr_value = is_put;
    assign last_rank    = RANK_BITS'(count_reg - CNT_BITS'(1));

    // Rank bound below which entries age
    always_comb
    begin
        case (op)
            OP_HIT:   old_rank = rank_link[ENTRIES];
            OP_FILL:  old_rank = RANK_BITS'(count_reg);
            OP_EVICT: old_rank = last_rank;
            default:  old_rank = '0;
        endcase
    end

    // Cell row
    assign free_link[0]  = 1'b0;
    assign hit_link[0]   = 1'b0;
    assign value_link[0] = '0;
    assign rank_link[0]  = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lrukv_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .RANK_BITS  (RANK_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .key       (req.key),
            .value     (req.value),
            .old_rank  (old_rank),
            .last_rank (last_rank),
            .free_in   (free_link[i]),
            .free_out  (free_link[i+1]),
            .hit_in    (hit_link[i]),
            .hit_out   (hit_link[i+1]),
            .value_in  (value_link[i]),
            .value_out (value_link[i+1]),
            .rank_in   (rank_link[i]),
            .rank_out  (rank_link[i+1]),
            .valid     (valid_vec[i]),
            .key_match (match_vec[i])
        );
    end

    // Fill count and result valid
    assign count_next     = count_reg + CNT_BITS'(op == OP_FILL);
    assign out_valid_next = accept ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.data;
            end
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg        <= hit_link[ENTRIES];
            read_value_reg <= (hit_link[ENTRIES] && !is_put) ? value_link[ENTRIES] : '0;
            evicted_reg    <= (op == OP_EVICT);
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = hit_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.evicted    = evicted_reg;

    // Checks
    `LRUKV_ASSERT_SAME(a_count_tracks_valid, 1'b1, $countones(valid_vec) == count_reg)
    `LRUKV_ASSERT_SAME(a_key_unique, 1'b1, $onehot0(match_vec))
    `LRUKV_ASSERT_NEXT(a_evict_keeps_count, op == OP_EVICT, $stable(count_reg))

endmodule

// ===== rtl/core/lrukv_cell.sv =====
// One cache entry: key, value, valid bit and recency rank, chained to its neighbors.
module lrukv_cell #(
    parameter int KEY_BITS   = lrukv_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lrukv_pkg::DEF_VALUE_BITS,
    parameter int RANK_BITS  = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lrukv_pkg::lrukv_ctl_t    ctl,
    input  logic [KEY_BITS-1:0]      key,
    input  logic [VALUE_BITS-1:0]    value,
    input  logic [RANK_BITS-1:0]     old_rank,
    input  logic [RANK_BITS-1:0]     last_rank,
    input  logic                     free_in,
    output logic                     free_out,
    input  logic                     hit_in,
    output logic                     hit_out,
    input  logic [VALUE_BITS-1:0]    value_in,
    output logic [VALUE_BITS-1:0]    value_out,
    input  logic [RANK_BITS-1:0]     rank_in,
    output logic [RANK_BITS-1:0]     rank_out,
    output logic                     valid,
    output logic                     key_match
);
    import lrukv_pkg::*;

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  valid_reg;
    logic                  valid_next;
    logic [RANK_BITS-1:0]  rank_reg;
    logic [RANK_BITS-1:0]  rank_next;
    logic                  first_free;
    logic                  victim;
    logic                  sel;

    // Lookup and chain links
    assign key_match  = valid_reg && (key_reg == key);
    assign first_free = !valid_reg && !free_in;
    assign victim     = valid_reg && (rank_reg == last_rank);
    assign free_out   = free_in | !valid_reg;
    assign hit_out    = hit_in | key_match;
    assign value_out  = value_in | (key_match ? value_reg : '0);
    assign rank_out   = rank_in | (key_match ? rank_reg : '0);
    assign valid      = valid_reg;

    // Is this cell the one the operation lands on
    always_comb
    begin
        case (ctl.op)
            OP_HIT:   sel = key_match;
            OP_FILL:  sel = first_free;
            OP_EVICT: sel = victim;
            default:  sel = 1'b0;
        endcase
    end

    // Rank: target becomes most recent, more recent entries age by one
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (sel)
        begin
            valid_next = 1'b1;
            rank_next  = '0;
        end
        else if ((ctl.op != OP_NONE) && valid_reg && (rank_reg < old_rank))
        begin
            rank_next = rank_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            key_reg <= key;
            if (ctl.wr_value)
            begin
                value_reg <= value;
            end
        end
    end

endmodule
